### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbct: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbct: assertion failed");

`endif

### src/mbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_pkg
// Types, widths and constants of the mask centroid tracker.
// ----------------------------------------------------------------------------
package mbct_pkg;

   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int TOTAL_W    = 28;
   localparam int COUNT_W    = 19;
   localparam int MISS_W     = 8;
   localparam int SIZE_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;
   localparam logic [COL_W:0] FRAME_COL_LIMIT = (COL_W + 1)'(FRAME_WIDTH);
   localparam logic [ROW_W:0] FRAME_ROW_LIMIT = (ROW_W + 1)'(FRAME_HEIGHT);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PIXELS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT    = 3'd7;

   // Register reset values
   localparam logic [COL_W-1:0]   RST_WINDOW_LEFT   = 10'd80;
   localparam logic [COL_W-1:0]   RST_WINDOW_RIGHT  = 10'd450;
   localparam logic [ROW_W-1:0]   RST_WINDOW_TOP    = 9'd50;
   localparam logic [ROW_W-1:0]   RST_WINDOW_BOTTOM = 9'd260;
   localparam logic [COUNT_W-1:0] RST_MIN_PIXELS    = 19'd10;
   localparam logic [MISS_W-1:0]  RST_LOST_LIMIT    = 8'd10;
   localparam logic [SIZE_W-1:0]  RST_OUT_WIDTH     = 12'd1920;
   localparam logic [SIZE_W-1:0]  RST_OUT_HEIGHT    = 12'd1080;

   // Shared divider
   localparam int DIVIDEND_W = TOTAL_W;
   localparam int DIVISOR_W  = COUNT_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [COL_W-1:0] pixel_column;
      logic [ROW_W-1:0] pixel_row;
      logic             pixel_set;
      logic             frame_last;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  centre_column;
      logic [ROW_W-1:0]  centre_row;
      logic [SIZE_W-1:0] screen_column;
      logic [SIZE_W-1:0] screen_row;
      logic              found_now;
      logic              object_lost;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0]   window_left;
      logic [COL_W-1:0]   window_right;
      logic [ROW_W-1:0]   window_top;
      logic [ROW_W-1:0]   window_bottom;
      logic [COUNT_W-1:0] min_pixels;
      logic [MISS_W-1:0]  lost_limit;
      logic [SIZE_W-1:0]  out_width;
      logic [SIZE_W-1:0]  out_height;
   } cfg_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] column_total;
      logic [TOTAL_W-1:0] row_total;
      logic [COUNT_W-1:0] set_count;
   } totals_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

### src/masked_blob_centroid_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_blob_centroid_tracker_unit
// Tracks the centroid of set mask pixels in a window and maps it to
// projector coordinates, one result per frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle; intake only stalls when the two-entry
// queue of finished frame totals is full. Each frame is then resolved by a
// sequencer around one shared restoring divider: two centroid and two
// scaling divisions when the object is found, two scaling ones when it
// is missed. Frames that come faster queue up and then stall the pixel
// stream. Configuration registers reset to their documented values; the
// user must write them only while idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module masked_blob_centroid_tracker_unit import mbct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        push, pop, queue_full, queue_empty;
   totals_type  push_data, pop_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LEFT:   cfg_in.window_left   = csr_wr_data[COL_W-1:0];
            CSR_WINDOW_RIGHT:  cfg_in.window_right  = csr_wr_data[COL_W-1:0];
            CSR_WINDOW_TOP:    cfg_in.window_top    = csr_wr_data[ROW_W-1:0];
            CSR_WINDOW_BOTTOM: cfg_in.window_bottom = csr_wr_data[ROW_W-1:0];
            CSR_MIN_PIXELS:    cfg_in.min_pixels    = csr_wr_data[COUNT_W-1:0];
            CSR_LOST_LIMIT:    cfg_in.lost_limit    = csr_wr_data[MISS_W-1:0];
            CSR_OUT_WIDTH:     cfg_in.out_width     = csr_wr_data[SIZE_W-1:0];
            CSR_OUT_HEIGHT:    cfg_in.out_height    = csr_wr_data[SIZE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left   <= RST_WINDOW_LEFT;
         cfg_ff.window_right  <= RST_WINDOW_RIGHT;
         cfg_ff.window_top    <= RST_WINDOW_TOP;
         cfg_ff.window_bottom <= RST_WINDOW_BOTTOM;
         cfg_ff.min_pixels    <= RST_MIN_PIXELS;
         cfg_ff.lost_limit    <= RST_LOST_LIMIT;
         cfg_ff.out_width     <= RST_OUT_WIDTH;
         cfg_ff.out_height    <= RST_OUT_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   mbct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   mbct_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mbct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

### src/mbct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_front
// Pixel intake: window test and saturating totals, one pixel a cycle unless the queue is full.
// Pushes the frame totals into the queue on the last pixel of a frame.
// ----------------------------------------------------------------------------
module mbct_front import mbct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  logic       queue_full,
   output logic       push,
   output totals_type push_data
);

   logic [TOTAL_W-1:0] col_total_ff, col_total_in;
   logic [TOTAL_W-1:0] row_total_ff, row_total_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic               in_window;
   logic [TOTAL_W:0]   col_sum, row_sum;
   logic [COUNT_W:0]   count_sum;
   totals_type         acc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      in_window = req_data.pixel_set
         && ({1'b0, req_data.pixel_column} < FRAME_COL_LIMIT)
         && ({1'b0, req_data.pixel_row} < FRAME_ROW_LIMIT)
         && (req_data.pixel_column >= cfg.window_left)
         && (req_data.pixel_column < cfg.window_right)
         && (req_data.pixel_row >= cfg.window_top)
         && (req_data.pixel_row < cfg.window_bottom);

      col_sum   = {1'b0, col_total_ff}
                + {{(TOTAL_W + 1 - COL_W){1'b0}}, req_data.pixel_column};
      row_sum   = {1'b0, row_total_ff}
                + {{(TOTAL_W + 1 - ROW_W){1'b0}}, req_data.pixel_row};
      count_sum = {1'b0, count_ff} + (COUNT_W + 1)'(1);

      acc.column_total = col_total_ff;
      acc.row_total    = row_total_ff;
      acc.set_count    = count_ff;
      if (in_window) begin
         // saturate on overlong frames
         acc.column_total = col_sum[TOTAL_W] ? '1 : col_sum[TOTAL_W-1:0];
         acc.row_total    = row_sum[TOTAL_W] ? '1 : row_sum[TOTAL_W-1:0];
         acc.set_count    = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
      end

      push         = accept && req_data.frame_last;
      push_data    = acc;
      col_total_in = col_total_ff;
      row_total_in = row_total_ff;
      count_in     = count_ff;
      if (accept) begin
         if (req_data.frame_last) begin
            col_total_in = '0;
            row_total_in = '0;
            count_in     = '0;
         end else begin
            col_total_in = acc.column_total;
            row_total_in = acc.row_total;
            count_in     = acc.set_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_total_ff <= '0;
         row_total_ff <= '0;
         count_ff     <= '0;
      end else begin
         col_total_ff <= col_total_in;
         row_total_ff <= row_total_in;
         count_ff     <= count_in;
      end
   end

endmodule
`default_nettype wire

### src/mbct_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_queue
// Short queue of frame totals between the intake and the back end.
// ----------------------------------------------------------------------------
module mbct_queue import mbct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  totals_type push_data,
   input  logic       pop,
   output totals_type pop_data,
   output logic       full,
   output logic       empty
);

   totals_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full     = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### src/mbct_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_div
// Restoring divider, one quotient bit a cycle. Shared by the centroid and
// the projector scaling steps.
// ----------------------------------------------------------------------------
module mbct_div import mbct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W+1:0]  diff;
   logic                  ge;
   logic                  last;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      ge    = !diff[DIVISOR_W+1];
      last  = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

      busy_in = busy_ff;
      done_in = busy_ff && last;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (last) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff + 1'b1;
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

### src/mbct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_back
// Per-frame sequencer: centroid, hold and miss tracking, projector scaling
// and the result register.
// ----------------------------------------------------------------------------
module mbct_back import mbct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        queue_empty,
   input  totals_type  queue_data,
   output logic        pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_COL  = 3'd1;
   localparam logic [2:0] ST_DIV_ROW  = 3'd2;
   localparam logic [2:0] ST_SCALE    = 3'd3;
   localparam logic [2:0] ST_DIV_SCOL = 3'd4;
   localparam logic [2:0] ST_DIV_SROW = 3'd5;
   localparam logic [2:0] ST_EMIT     = 3'd6;

   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   logic [2:0]          state_ff, state_in;
   logic [TOTAL_W-1:0]  row_total_ff, row_total_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                found_ff, found_in;
   logic                lost_ff, lost_in;
   logic [COL_W-1:0]    held_col_ff, held_col_in;
   logic [ROW_W-1:0]    held_row_ff, held_row_in;
   logic [MISS_W-1:0]   miss_ff, miss_in;
   logic [SIZE_W-1:0]   scol_ff, scol_in;
   logic [SIZE_W-1:0]   srow_ff, srow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                lost_now;
   logic [COL_W-1:0]    col_diff, col_span;
   logic [ROW_W-1:0]    row_diff, row_span;
   logic [COL_W+SIZE_W-1:0] col_prod;
   logic [ROW_W+SIZE_W-1:0] row_prod;
   logic [SIZE_W-1:0]   q_screen;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      lost_now = (miss_ff > cfg.lost_limit);
      col_diff = held_col_ff - cfg.window_left;
      col_span = cfg.window_right - cfg.window_left;
      row_diff = cfg.window_bottom - held_row_ff;
      row_span = cfg.window_bottom - cfg.window_top;
      col_prod = col_diff * cfg.out_width;
      row_prod = row_diff * cfg.out_height;
      q_screen = (div_rsp.quotient[DIVIDEND_W-1:SIZE_W] != '0) ? '1
               : div_rsp.quotient[SIZE_W-1:0];

      state_in     = state_ff;
      row_total_in = row_total_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      lost_in      = lost_ff;
      held_col_in  = held_col_ff;
      held_row_in  = held_row_ff;
      miss_in      = miss_ff;
      scol_in      = scol_ff;
      srow_in      = srow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop          = 1'b1;
               row_total_in = queue_data.row_total;
               count_in     = queue_data.set_count;
               found_in     = (queue_data.set_count > cfg.min_pixels);
               if (queue_data.set_count > cfg.min_pixels) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = queue_data.column_total;
                  div_req.divisor  = queue_data.set_count;
                  state_in         = ST_DIV_COL;
               end else begin
                  if (miss_ff != MISS_MAX) begin
                     miss_in = miss_ff + 1'b1;
                  end
                  state_in = ST_SCALE;
               end
            end
         end
         ST_DIV_COL: begin
            if (div_rsp.done) begin
               held_col_in = (div_rsp.quotient[DIVIDEND_W-1:COL_W] != '0) ? '1
                           : div_rsp.quotient[COL_W-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = row_total_ff;
               div_req.divisor  = count_ff;
               state_in         = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_rsp.done) begin
               held_row_in = (div_rsp.quotient[DIVIDEND_W-1:ROW_W] != '0) ? '1
                           : div_rsp.quotient[ROW_W-1:0];
               miss_in     = '0;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            lost_in       = lost_now;
            div_req.start = 1'b1;
            // a lost object, a degenerate window or a point left of it scales to zero
            if (!lost_now && (cfg.window_right > cfg.window_left)
                  && (held_col_ff > cfg.window_left)) begin
               div_req.dividend = DIVIDEND_W'(col_prod);
               div_req.divisor  = DIVISOR_W'(col_span);
            end else begin
               div_req.dividend = '0;
               div_req.divisor  = DIVISOR_W'(1);
            end
            state_in = ST_DIV_SCOL;
         end
         ST_DIV_SCOL: begin
            if (div_rsp.done) begin
               scol_in       = q_screen;
               div_req.start = 1'b1;
               if (!lost_ff && (cfg.window_bottom > cfg.window_top)
                     && (cfg.window_bottom > held_row_ff)) begin
                  div_req.dividend = DIVIDEND_W'(row_prod);
                  div_req.divisor  = DIVISOR_W'(row_span);
               end else begin
                  div_req.dividend = '0;
                  div_req.divisor  = DIVISOR_W'(1);
               end
               state_in = ST_DIV_SROW;
            end
         end
         ST_DIV_SROW: begin
            if (div_rsp.done) begin
               srow_in  = q_screen;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.centre_column = lost_ff ? '0 : held_col_ff;
               rsp_data_in.centre_row    = lost_ff ? '0 : held_row_ff;
               rsp_data_in.screen_column = scol_ff;
               rsp_data_in.screen_row    = srow_ff;
               rsp_data_in.found_now     = found_ff;
               rsp_data_in.object_lost   = lost_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_col_ff  <= '0;
         held_row_ff  <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_col_ff  <= held_col_in;
         held_row_ff  <= held_row_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_total_ff <= row_total_in;
      count_ff     <= count_in;
      found_ff     <= found_in;
      lost_ff      <= lost_in;
      scol_ff      <= scol_in;
      srow_ff      <= srow_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

### src/mbct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_checker
// Port-level checks on the tracker's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbct_checker import mbct_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled transaction holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // lost results carry no position
   `ASSERT_IMPLY(a_lost_zero, clock, reset, rsp_valid && rsp_data.object_lost, rsp_data.centre_column == '0 && rsp_data.centre_row == '0 && rsp_data.screen_column == '0 && rsp_data.screen_row == '0 && !rsp_data.found_now)

   // a found frame clears the misses, so it is never lost
   `ASSERT_IMPLY(a_found_not_lost, clock, reset, rsp_valid && rsp_data.found_now, !rsp_data.object_lost)

   // reset drops any pending transaction
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind masked_blob_centroid_tracker_unit mbct_checker u_checker (.*);
`default_nettype wire

### sim/masked_blob_centroid_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_blob_centroid_tracker_unit_tb
// Self-checking bench for the mask centroid tracker. A short scripted pixel
// sequence runs first. Randomized frames follow under a series of window,
// threshold and projector settings. Scripted results are checked against
// typed values, others against a cycle-free tracking model in the bench.
// ----------------------------------------------------------------------------
module masked_blob_centroid_tracker_unit_tb;
   import mbct_pkg::*;

   localparam int    HALF_PERIOD  = 4;
   localparam int    RESET_CYCLES = 6;
   localparam int    ITEM_TARGET  = 1600;
   localparam int    SETTLE_GAP   = 400;
   localparam int    HOLD_CYCLES  = 3000;
   localparam int    NUM_SCRIPT   = 21;
   localparam int    PRINT_LIMIT  = 30;
   localparam longint TIMEOUT_NS  = 12_000_000;

   localparam logic [TOTAL_W-1:0] TOTAL_FULL  = '1;
   localparam logic [COUNT_W-1:0] COUNT_FULL  = '1;
   localparam logic [MISS_W-1:0]  MISS_FULL   = '1;
   localparam logic [SIZE_W-1:0]  SCREEN_FULL = '1;

   typedef struct {
      req_type px;
      bit      typed;
      rsp_type want;
   } script_row_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_WINDOW_LEFT;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // tracking model state
   cfg_type tk_cfg = '{RST_WINDOW_LEFT, RST_WINDOW_RIGHT, RST_WINDOW_TOP,
                       RST_WINDOW_BOTTOM, RST_MIN_PIXELS, RST_LOST_LIMIT,
                       RST_OUT_WIDTH, RST_OUT_HEIGHT};
   logic [TOTAL_W-1:0] col_sum    = '0;
   logic [TOTAL_W-1:0] row_sum    = '0;
   logic [COUNT_W-1:0] pix_count  = '0;
   logic [COL_W-1:0]   held_col   = '0;
   logic [ROW_W-1:0]   held_row   = '0;
   logic [MISS_W-1:0]  misses     = '0;

   rsp_type pending_centroids [$];
   int      pixels_sent        = 0;
   int      results_seen       = 0;
   int      mismatch_count     = 0;
   int      sender_idle_pct    = 0;
   int      receiver_stall_pct = 0;
   int      hold_left          = 0;
   bit      hold_request       = 1'b0;

   // Default settings: window 80..449 x 50..259, min 10, lost 10, 1920 x 1080.
   script_row_t pixel_script [NUM_SCRIPT] = '{
      // pixel off the frame, empty frame
      '{'{10'd1023, 9'd511, 1'b1, 1'b1}, 1'b1, '{10'd0, 9'd0, 12'd0, 12'd1337, 1'b0, 1'b0}},
      '{'{10'd639,  9'd479, 1'b1, 1'b0}, 1'b0, '0},
      // window corners, inclusive and exclusive edges
      '{'{10'd80,   9'd50,  1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd449,  9'd259, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd450,  9'd100, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd100,  9'd260, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd79,   9'd100, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd100,  9'd49,  1'b1, 1'b0}, 1'b0, '0},
      // two pixels counted, below the minimum
      '{'{10'd200,  9'd200, 1'b0, 1'b1}, 1'b1, '{10'd0, 9'd0, 12'd0, 12'd1337, 1'b0, 1'b0}},
      // eleven pixels on one spot, the last one closing the frame
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd265,  9'd155, 1'b1, 1'b1}, 1'b1, '{10'd265, 9'd155, 12'd960, 12'd540, 1'b1, 1'b0}},
      // miss: held position repeated
      '{'{10'd0,    9'd0,   1'b0, 1'b1}, 1'b1, '{10'd265, 9'd155, 12'd960, 12'd540, 1'b0, 1'b0}}
   };

   masked_blob_centroid_tracker_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [SIZE_W-1:0] scaled_coord(input longint diff, input longint size,
                                                      input longint span);
      longint v;
      v = diff * size / span;
      if (v < 0) return '0;
      if (v > longint'(SCREEN_FULL)) return SCREEN_FULL;
      return v[SIZE_W-1:0];
   endfunction

   // Accumulate one pixel; on the frame's last pixel produce the frame result.
   function automatic void track_pixel(input req_type px, output bit emits,
                                       output rsp_type rsp);
      logic [TOTAL_W-1:0] qc;
      logic [TOTAL_W-1:0] qr;
      bit found;
      bit lost;
      rsp   = '0;
      emits = px.frame_last;
      if (px.pixel_set && px.pixel_column < FRAME_WIDTH && px.pixel_row < FRAME_HEIGHT &&
          px.pixel_column >= tk_cfg.window_left && px.pixel_column < tk_cfg.window_right &&
          px.pixel_row >= tk_cfg.window_top && px.pixel_row < tk_cfg.window_bottom) begin
         col_sum = (col_sum > TOTAL_FULL - px.pixel_column) ? TOTAL_FULL
                                                             : col_sum + px.pixel_column;
         row_sum = (row_sum > TOTAL_FULL - px.pixel_row) ? TOTAL_FULL
                                                         : row_sum + px.pixel_row;
         if (pix_count != COUNT_FULL) pix_count = pix_count + 1'b1;
      end
      if (!px.frame_last) return;

      found = pix_count > tk_cfg.min_pixels;
      if (found) begin
         qc = col_sum / pix_count;
         qr = row_sum / pix_count;
         held_col = (qc > TOTAL_W'({COL_W{1'b1}})) ? '1 : qc[COL_W-1:0];
         held_row = (qr > TOTAL_W'({ROW_W{1'b1}})) ? '1 : qr[ROW_W-1:0];
         misses   = '0;
      end else if (misses != MISS_FULL) begin
         misses = misses + 1'b1;
      end
      col_sum   = '0;
      row_sum   = '0;
      pix_count = '0;

      lost = misses > tk_cfg.lost_limit;
      rsp.found_now   = found;
      rsp.object_lost = lost;
      if (!lost) begin
         rsp.centre_column = held_col;
         rsp.centre_row    = held_row;
         if (tk_cfg.window_right > tk_cfg.window_left)
            rsp.screen_column = scaled_coord(longint'(held_col) - longint'(tk_cfg.window_left),
                                             tk_cfg.out_width,
                                             tk_cfg.window_right - tk_cfg.window_left);
         if (tk_cfg.window_bottom > tk_cfg.window_top)
            rsp.screen_row = scaled_coord(longint'(tk_cfg.window_bottom) - longint'(held_row),
                                          tk_cfg.out_height,
                                          tk_cfg.window_bottom - tk_cfg.window_top);
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] result %0d %s: got %0d, want %0d", $realtime, results_seen, field,
                  got, want);
   endtask

   // Offer one pixel transaction; hold it until accepted, then predict.
   task automatic push_pixel(input req_type px, input bit typed, input rsp_type typed_rsp);
      int      gap = 0;
      bit      emits;
      rsp_type predicted;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      track_pixel(px, emits, predicted);
      if (emits) pending_centroids.push_back(typed ? typed_rsp : predicted);
      pixels_sent++;
   endtask

   task automatic send_frame(input int len);
      req_type px;
      int      density;
      int      pick;
      density = $urandom_range(100, 10);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 70 && tk_cfg.window_right > tk_cfg.window_left &&
             tk_cfg.window_bottom > tk_cfg.window_top) begin
            px.pixel_column = $urandom_range(tk_cfg.window_right - 1, tk_cfg.window_left);
            px.pixel_row    = $urandom_range(tk_cfg.window_bottom - 1, tk_cfg.window_top);
         end else if (pick < 88) begin
            px.pixel_column = $urandom_range(FRAME_WIDTH - 1);
            px.pixel_row    = $urandom_range(FRAME_HEIGHT - 1);
         end else begin
            px.pixel_column = $urandom_range((1 << COL_W) - 1);
            px.pixel_row    = $urandom_range((1 << ROW_W) - 1);
         end
         px.pixel_set  = $urandom_range(99) < density;
         px.frame_last = (i == len - 1);
         push_pixel(px, 1'b0, '0);
      end
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      put_reg(CSR_WINDOW_LEFT,   c.window_left);
      put_reg(CSR_WINDOW_RIGHT,  c.window_right);
      put_reg(CSR_WINDOW_TOP,    c.window_top);
      put_reg(CSR_WINDOW_BOTTOM, c.window_bottom);
      put_reg(CSR_MIN_PIXELS,    c.min_pixels);
      put_reg(CSR_LOST_LIMIT,    c.lost_limit);
      put_reg(CSR_OUT_WIDTH,     c.out_width);
      put_reg(CSR_OUT_HEIGHT,    c.out_height);
      csr_wr_en <= 1'b0;
      tk_cfg = c;
   endtask

   // Drop valid, wait for every outstanding frame result, then let the unit settle.
   task automatic wait_results_drained(input int settle);
      req_valid <= 1'b0;
      while (pending_centroids.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Result side back-pressure, with an optional long hold counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < receiver_stall_pct;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_centroids.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = pending_centroids.pop_front();
            if (rsp_data.centre_column !== want.centre_column)
               report_mismatch("centre_column", rsp_data.centre_column, want.centre_column);
            if (rsp_data.centre_row !== want.centre_row)
               report_mismatch("centre_row", rsp_data.centre_row, want.centre_row);
            if (rsp_data.screen_column !== want.screen_column)
               report_mismatch("screen_column", rsp_data.screen_column, want.screen_column);
            if (rsp_data.screen_row !== want.screen_row)
               report_mismatch("screen_row", rsp_data.screen_row, want.screen_row);
            if (rsp_data.found_now !== want.found_now)
               report_mismatch("found_now", rsp_data.found_now, want.found_now);
            if (rsp_data.object_lost !== want.object_lost)
               report_mismatch("object_lost", rsp_data.object_lost, want.object_lost);
         end
         results_seen++;
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("masked_blob_centroid_tracker_unit regression: fail");
      $finish;
   end

   initial begin
      cfg_type plan;
      int      budget;
      int      phase_start;
      int      len;
      int      roll;
      bit      paused;
      req_type px;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (pixel_script[i])
         push_pixel(pixel_script[i].px, pixel_script[i].typed, pixel_script[i].want);
      wait_results_drained(SETTLE_GAP);

      for (int phase = 0; phase < 7 || pixels_sent < ITEM_TARGET; phase++) begin
         budget = 150;
         case (phase)
            0: plan = '{10'd0, 10'd640, 9'd0, 9'd480, 19'd0, 8'd255, 12'd4095, 12'd4095};
            1: begin
               plan   = '{10'd639, 10'd640, 9'd479, 9'd480, 19'd0, 8'd0, 12'd1, 12'd1};
               budget = 60;
            end
            2: begin
               // empty window both ways: nothing counts, scaling forced to zero
               plan   = '{10'd500, 10'd100, 9'd300, 9'd10, 19'd0, 8'd3, 12'd2000, 12'd2000};
               budget = 60;
            end
            3: begin
               // single pixel frames, all misses: drive the miss counter to saturation
               plan   = '{RST_WINDOW_LEFT, RST_WINDOW_RIGHT, RST_WINDOW_TOP, RST_WINDOW_BOTTOM,
                          19'd307200, 8'd254, RST_OUT_WIDTH, RST_OUT_HEIGHT};
               budget = 300;
            end
            4: begin
               plan   = '{10'd0, 10'd640, 9'd0, 9'd480, 19'd0, 8'd255, 12'd1920, 12'd1080};
               budget = 80;
            end
            5: begin
               // held position far outside a one pixel window: clamp high
               plan   = '{10'd0, 10'd1, 9'd470, 9'd471, 19'd307200, 8'd255, 12'd4095, 12'd4095};
               budget = 60;
            end
            6: begin
               // held position before the window start: clamp to zero
               plan   = '{10'd600, 10'd640, 9'd0, 9'd10, 19'd307200, 8'd255, 12'd4095, 12'd4095};
               budget = 60;
            end
            default: begin
               plan.window_left   = $urandom_range(FRAME_WIDTH - 1);
               plan.window_right  = ($urandom_range(9) == 0) ? $urandom_range(FRAME_WIDTH, 1)
                                    : $urandom_range(FRAME_WIDTH, plan.window_left + 1);
               plan.window_top    = $urandom_range(FRAME_HEIGHT - 1);
               plan.window_bottom = ($urandom_range(9) == 0) ? $urandom_range(FRAME_HEIGHT, 1)
                                    : $urandom_range(FRAME_HEIGHT, plan.window_top + 1);
               roll = $urandom_range(9);
               plan.min_pixels    = (roll < 7) ? $urandom_range(6)
                                    : (roll < 9) ? $urandom_range(40) : $urandom_range(307200);
               plan.lost_limit    = $urandom_range(1) ? $urandom_range(5) : $urandom_range(255);
               plan.out_width     = $urandom_range(4095, 1);
               plan.out_height    = $urandom_range(4095, 1);
            end
         endcase
         load_config(plan);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         // back up the result side so the frame queue fills and intake stalls
         if (phase == 0) hold_request = 1'b1;

         phase_start = pixels_sent;
         paused      = 1'b0;
         while (pixels_sent - phase_start < budget) begin
            if (phase == 7 && !paused && pixels_sent - phase_start >= budget / 2) begin
               wait_results_drained(0);
               paused = 1'b1;
            end
            if (phase == 3)
               len = 1;
            else if ($urandom_range(19) == 0)
               len = $urandom_range(120, 21);
            else
               len = $urandom_range(20, 1);
            send_frame(len);
         end
         if (phase == 4) begin
            // pin the held position near the frame centre for the clamp phases
            px = '{10'd320, 9'd240, 1'b1, 1'b0};
            push_pixel(px, 1'b0, '0);
            px.frame_last = 1'b1;
            push_pixel(px, 1'b0, '0);
         end
         wait_results_drained(SETTLE_GAP);
      end

      if (mismatch_count == 0)
         $display("masked_blob_centroid_tracker_unit regression: pass");
      else
         $display("masked_blob_centroid_tracker_unit regression: fail");
      $finish;
   end

endmodule

### masked_blob_centroid_tracker_unit.f
+incdir+src
src/mbct_pkg.sv
src/mbct_front.sv
src/mbct_queue.sv
src/mbct_div.sv
src/mbct_back.sv
src/masked_blob_centroid_tracker_unit.sv
src/mbct_checker.sv
sim/masked_blob_centroid_tracker_unit_tb.sv
